[hw/rtl/xs1024_pkg.sv]
package xs1024_pkg;

    // Request and word geometry
    localparam int MAX_READ = 64;
    localparam int CNT_W    = 7;
    localparam int WORD_W   = 64;
    localparam int HALF_W   = 32;
    localparam int IDX_W    = 4;
    localparam int NWORDS   = 16;

    // Generator constants
    localparam logic [WORD_W-1:0] XS_MUL = 64'd1181783497276652981;
    localparam int XS_A = 31;
    localparam int XS_B = 11;
    localparam int XS_C = 30;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_MIX,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_EMIT
    } xs_state_t;

    // Seed word for each generator slot
    function automatic logic [WORD_W-1:0] seed_word(input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] w;
        case (idx)
            4'd0:    w = 64'h84242f96eca9c41d;
            4'd1:    w = 64'ha3c65b8776f96855;
            4'd2:    w = 64'h5b34a39f070b5837;
            4'd3:    w = 64'h4489affce4f31a1e;
            4'd4:    w = 64'h2ffeeb0a48316f40;
            4'd5:    w = 64'hdc2d9891fe68c022;
            4'd6:    w = 64'h3659132bb12fea70;
            4'd7:    w = 64'haac17d8efa43cab8;
            4'd8:    w = 64'hc4cb815590989b13;
            4'd9:    w = 64'h5ee975283d71c93b;
            4'd10:   w = 64'h691548c86c1bd540;
            4'd11:   w = 64'h7910c41d10a1e6a5;
            4'd12:   w = 64'h0b5fc64563b3e2a8;
            4'd13:   w = 64'h047f7684e9fc949d;
            4'd14:   w = 64'hb99181f2d8f685ca;
            default: w = 64'h284600e3f30e38c3;
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/xs1024_word_mem.sv]
module xs1024_word_mem (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             we,
    input  logic [xs1024_pkg::IDX_W-1:0]     waddr,
    input  logic [xs1024_pkg::WORD_W-1:0]    wdata,
    input  logic [xs1024_pkg::IDX_W-1:0]     raddr,
    output logic [xs1024_pkg::WORD_W-1:0]    rdata
);

    logic [xs1024_pkg::WORD_W-1:0] mem [xs1024_pkg::NWORDS];
    logic [xs1024_pkg::NWORDS-1:0] valid_reg;
    logic [xs1024_pkg::WORD_W-1:0] rdata_reg;

    // Mark written slots; unwritten slots read as their seed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= valid_reg[raddr] ? mem[raddr] : xs1024_pkg::seed_word(raddr);
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/xs1024_mul32.sv]
module xs1024_mul32 (
    input  logic                               clk,
    input  logic [xs1024_pkg::HALF_W-1:0]      a,
    input  logic [xs1024_pkg::HALF_W-1:0]      b,
    output logic [xs1024_pkg::WORD_W-1:0]      p
);

    logic [xs1024_pkg::WORD_W-1:0] p_reg;

    // Register the full 64-bit partial product
    always_ff @(posedge clk)
    begin
        p_reg <= {{xs1024_pkg::HALF_W{1'b0}}, a} * {{xs1024_pkg::HALF_W{1'b0}}, b};
    end

    assign p = p_reg;

endmodule

[hw/rtl/xorshift1024_star_byte_source.sv]
// xorshift1024* byte source. Each request asks for byte_count bytes (0 gives
// nothing, above 64 is cut to 64) and is answered with that many bytes, one
// per handshake, least significant byte of each 64-bit word first, the final
// one flagged by last_byte. Bytes left over from the last word are served
// first when the request fits in them; otherwise they are dropped and new
// words are drawn. A byte leaves at most once per cycle. Drawing a word takes
// two reads of the 16-word state memory, one mix and write-back step, and
// three passes through the shared 32x32 multiplier plus an accumulate to
// form the low 64 bits of the product. A new request is taken only once the
// previous one is finished.
module xorshift1024_star_byte_source (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [xs1024_pkg::CNT_W-1:0]    byte_count,
    output logic                            byte_valid,
    input  logic                            byte_ready,
    output logic [7:0]                      random_byte,
    output logic                            last_byte
);

    xs1024_pkg::xs_state_t state_reg, state_next;

    logic [xs1024_pkg::IDX_W-1:0]   word_index_reg, word_index_next;
    logic [xs1024_pkg::WORD_W-1:0]  held_word_reg, held_word_next;
    logic [3:0]                     bytes_left_reg, bytes_left_next;
    logic [xs1024_pkg::CNT_W-1:0]   rest_reg, rest_next;
    logic [2:0]                     pos_reg, pos_next;
    logic [xs1024_pkg::WORD_W-1:0]  w0_reg, w0_next;
    logic [xs1024_pkg::WORD_W-1:0]  mix_reg, mix_next;
    logic [xs1024_pkg::WORD_W-1:0]  acc_reg, acc_next;

    logic [xs1024_pkg::CNT_W-1:0]   req_cnt;
    logic [3:0]                     start_pos;
    logic                           req_take;
    logic                           byte_take;

    logic                           mem_we;
    logic [xs1024_pkg::IDX_W-1:0]   mem_raddr;
    logic [xs1024_pkg::IDX_W-1:0]   next_index;
    logic [xs1024_pkg::WORD_W-1:0]  mem_rdata;
    logic [xs1024_pkg::WORD_W-1:0]  w1x;
    logic [xs1024_pkg::WORD_W-1:0]  mix_word;

    logic [xs1024_pkg::HALF_W-1:0]  mul_a, mul_b;
    logic [xs1024_pkg::WORD_W-1:0]  mul_p;
    logic [xs1024_pkg::HALF_W-1:0]  upper_sum;

    // Saturate the request and find where leftover bytes start
    assign req_cnt   = (byte_count > xs1024_pkg::CNT_W'(xs1024_pkg::MAX_READ))
                       ? xs1024_pkg::CNT_W'(xs1024_pkg::MAX_READ) : byte_count;
    assign start_pos = 4'd8 - bytes_left_reg;
    assign req_take  = req_valid && req_ready;
    assign byte_take = byte_valid && byte_ready;

    // Generator step on the two words read from state memory
    assign next_index = word_index_reg + 1'b1;
    assign w1x        = mem_rdata ^ (mem_rdata << xs1024_pkg::XS_A);
    assign mix_word   = w1x ^ w0_reg ^ (w1x >> xs1024_pkg::XS_B)
                        ^ (w0_reg >> xs1024_pkg::XS_C);

    // Upper half correction for the 64-bit product
    assign upper_sum  = acc_reg[xs1024_pkg::WORD_W-1:xs1024_pkg::HALF_W]
                        + mul_p[xs1024_pkg::HALF_W-1:0];

    xs1024_word_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (next_index),
        .wdata (mix_word),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    xs1024_mul32 u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            xs1024_pkg::ST_IDLE:
            begin
                if (req_take && (req_cnt != '0))
                begin
                    if (req_cnt <= {3'b000, bytes_left_reg})
                        state_next = xs1024_pkg::ST_EMIT;
                    else
                        state_next = xs1024_pkg::ST_RD0;
                end
            end
            xs1024_pkg::ST_RD0:  state_next = xs1024_pkg::ST_RD1;
            xs1024_pkg::ST_RD1:  state_next = xs1024_pkg::ST_MIX;
            xs1024_pkg::ST_MIX:  state_next = xs1024_pkg::ST_MUL0;
            xs1024_pkg::ST_MUL0: state_next = xs1024_pkg::ST_MUL1;
            xs1024_pkg::ST_MUL1: state_next = xs1024_pkg::ST_MUL2;
            xs1024_pkg::ST_MUL2: state_next = xs1024_pkg::ST_ACC;
            xs1024_pkg::ST_ACC:  state_next = xs1024_pkg::ST_EMIT;
            xs1024_pkg::ST_EMIT:
            begin
                if (byte_take)
                begin
                    if (rest_reg == 7'd1)
                        state_next = xs1024_pkg::ST_IDLE;
                    else if (bytes_left_reg == 4'd1)
                        state_next = xs1024_pkg::ST_RD0;
                end
            end
            default: state_next = xs1024_pkg::ST_IDLE;
        endcase
    end

    // Outputs and unit controls
    always_comb
    begin
        req_ready  = 1'b0;
        byte_valid = 1'b0;
        mem_we     = 1'b0;
        mem_raddr  = word_index_reg;
        mul_a      = mix_reg[xs1024_pkg::HALF_W-1:0];
        mul_b      = xs1024_pkg::XS_MUL[xs1024_pkg::HALF_W-1:0];
        case (state_reg)
            xs1024_pkg::ST_IDLE: req_ready = 1'b1;
            xs1024_pkg::ST_RD1:  mem_raddr = next_index;
            xs1024_pkg::ST_MIX:  mem_we = 1'b1;
            xs1024_pkg::ST_MUL1:
            begin
                mul_b = xs1024_pkg::XS_MUL[xs1024_pkg::WORD_W-1:xs1024_pkg::HALF_W];
            end
            xs1024_pkg::ST_MUL2:
            begin
                mul_a = mix_reg[xs1024_pkg::WORD_W-1:xs1024_pkg::HALF_W];
            end
            xs1024_pkg::ST_EMIT: byte_valid = 1'b1;
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // Serve the selected byte of the held word
    assign random_byte = held_word_reg[{pos_reg, 3'b000} +: 8];
    assign last_byte   = (rest_reg == 7'd1);

    // Datapath updates
    always_comb
    begin
        word_index_next = word_index_reg;
        held_word_next  = held_word_reg;
        bytes_left_next = bytes_left_reg;
        rest_next       = rest_reg;
        pos_next        = pos_reg;
        w0_next         = w0_reg;
        mix_next        = mix_reg;
        acc_next        = acc_reg;
        case (state_reg)
            xs1024_pkg::ST_IDLE:
            begin
                if (req_take)
                begin
                    rest_next = req_cnt;
                    pos_next  = start_pos[2:0];
                end
            end
            xs1024_pkg::ST_RD1:
            begin
                w0_next = mem_rdata;
            end
            xs1024_pkg::ST_MIX:
            begin
                mix_next        = mix_word;
                word_index_next = next_index;
            end
            xs1024_pkg::ST_MUL1:
            begin
                acc_next = mul_p;
            end
            xs1024_pkg::ST_MUL2:
            begin
                acc_next = {upper_sum, acc_reg[xs1024_pkg::HALF_W-1:0]};
            end
            xs1024_pkg::ST_ACC:
            begin
                held_word_next  = {upper_sum, acc_reg[xs1024_pkg::HALF_W-1:0]};
                bytes_left_next = 4'd8;
                pos_next        = 3'd0;
            end
            xs1024_pkg::ST_EMIT:
            begin
                if (byte_take)
                begin
                    rest_next       = rest_reg - 1'b1;
                    bytes_left_next = bytes_left_reg - 1'b1;
                    pos_next        = pos_reg + 1'b1;
                end
            end
            default:
            begin
                rest_next = rest_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= xs1024_pkg::ST_IDLE;
            word_index_reg <= '0;
            held_word_reg  <= '0;
            bytes_left_reg <= '0;
            rest_reg       <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            word_index_reg <= word_index_next;
            held_word_reg  <= held_word_next;
            bytes_left_reg <= bytes_left_next;
            rest_reg       <= rest_next;
            pos_reg        <= pos_next;
        end
    end

    // Working registers of the word draw
    always_ff @(posedge clk)
    begin
        w0_reg  <= w0_next;
        mix_reg <= mix_next;
        acc_reg <= acc_next;
    end

endmodule

[hw/rtl/xs1024_checker.sv]
module xs1024_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_ready,
    input  logic [xs1024_pkg::CNT_W-1:0]    byte_count,
    input  logic                            byte_valid,
    input  logic                            byte_ready,
    input  logic [7:0]                      random_byte,
    input  logic                            last_byte
);

    // No new request is taken while bytes of the current one are pending
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid |-> !req_ready)
        else $error("request taken while bytes pending");

    // The final byte closes the request
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && byte_ready && last_byte) |=> (!byte_valid && req_ready))
        else $error("bytes continue after last byte");

    // A zero-count request returns straight to ready
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (byte_count == '0)) |=> (req_ready && !byte_valid))
        else $error("zero-count request produced work");

    // A stalled byte holds
    a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && !byte_ready) |=>
        (byte_valid && $stable(random_byte) && $stable(last_byte)))
        else $error("stalled byte changed");

endmodule

bind xorshift1024_star_byte_source xs1024_checker u_xs1024_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .byte_count  (byte_count),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .random_byte (random_byte),
    .last_byte   (last_byte)
);
